[src/spl_pkg.sv]
// Shared types, reply codes and character constants for the serial password
// lock controller. No dependencies.
package spl_pkg;

  localparam logic [3:0] MaxAttemptsReset = 4'd3;

  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChV     = 8'h76;  // 'v'
  localparam logic [7:0] ChP     = 8'h70;  // 'p'
  localparam logic [7:0] ChC     = 8'h63;  // 'c'
  localparam logic [7:0] ChH     = 8'h68;  // 'h'
  localparam logic [7:0] ChL     = 8'h6c;  // 'l'
  localparam logic [7:0] ChN     = 8'h6e;  // 'n'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'

  typedef enum logic [2:0] {
    ReplyNone    = 3'd0,
    ReplyUnknown = 3'd1,
    ReplyUserOk  = 3'd2,
    ReplyPassOk  = 3'd3,
    ReplyPassBad = 3'd4,
    ReplyLocked  = 3'd5,
    ReplyBadAct  = 3'd6
  } reply_e;

  // Result of one byte: reply and the output levels after the step.
  typedef struct packed {
    reply_e reply;
    logic   door;
    logic   light;
    logic   locked;
  } result_t;

  // Expected characters of the user name prefix "user".
  function automatic logic [7:0] name_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h75;  // 'u'
      2'd1:    ch = 8'h73;  // 's'
      2'd2:    ch = 8'h65;  // 'e'
      default: ch = 8'h72;  // 'r'
    endcase
    return ch;
  endfunction

endpackage

[src/serial_password_lock_controller.sv]
// Top level of the serial password lock controller: input register, state
// machine and output register. Depends on spl_pkg and spl_core.
//
// Usage: one received serial byte enters per transfer on the input channel
// (in_valid_i, in_stall_o, rx_byte_i). Each byte yields exactly one result
// transfer on the output channel (out_valid_o, out_stall_i) carrying the
// reply code and the door, light, alarm and buzzer levels after that byte.
// max_attempts is written through cfg_we_i / cfg_wdata_i while the block is
// idle; it takes effect on the next byte.
//
// A byte that transfers waits in the input register while the state machine
// decides, and the decision loads the output register. Throughput is one byte
// per cycle while the receiver does not stall; the combinational next-state
// logic of the state machine sets that rate.
// When the receiver stalls, the result holds in the output register and one
// more byte can wait in the input register; beyond that in_stall_o rises.
// Reset clears both valid flags, returns to user entry with door and light
// off, and restores max_attempts to three. The locked state is left only by
// reset.
module serial_password_lock_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] reply_code_o,
  output logic       door_on_o,
  output logic       light_on_o,
  output logic       alarm_on_o,
  output logic       buzzer_on_o
);
  import spl_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    core_res;
  logic       out_free;
  logic       step;

  // The output register can load when it is empty or its result leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_byte_q <= rx_byte_i;
    if (step) out_res_q <= core_res;
  end

  spl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .result_o    (core_res)
  );

  assign out_valid_o  = out_valid_q;
  assign reply_code_o = out_res_q.reply;
  assign door_on_o    = out_res_q.door;
  assign light_on_o   = out_res_q.light;
  assign alarm_on_o   = out_res_q.locked;
  assign buzzer_on_o  = out_res_q.locked;

`ifndef SYNTHESIS
  // A locked result is either the failing attempt itself or a locked reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_on_o |->
      (reply_code_o == ReplyLocked || reply_code_o == ReplyPassBad))
    else $error("alarm raised with an unexpected reply code");

  // Lockout is permanent until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_on_o |=> alarm_on_o)
    else $error("alarm dropped after lockout");

  // The input side stalls only behind a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && in_valid_q)
    else $error("input stalled without output backpressure");
`endif

endmodule

[src/spl_core.sv]
// Login and command state machine of the serial password lock controller.
// Holds the phase, counters and output levels; depends on spl_pkg.
module spl_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output spl_pkg::result_t result_o
);
  import spl_pkg::*;

  typedef enum logic [3:0] {
    PhUser = 4'b0001,
    PhPass = 4'b0010,
    PhCmd  = 4'b0100,
    PhLock = 4'b1000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] count_q, count_d;
  logic       match_q, match_d;
  logic [3:0] digit_q, digit_d;
  logic [3:0] fails_q, fails_d;
  logic       door_q, door_d;
  logic       light_q, light_d;
  logic [3:0] max_att_q;
  reply_e     reply;

  logic [2:0] count_inc;
  logic [3:0] fails_inc;
  logic       user_match;
  logic [7:0] pass_char;

  assign count_inc = 3'(count_q + 3'd1);
  assign fails_inc = 4'(fails_q + 4'd1);
  assign pass_char = {4'h3, digit_q};

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    match_d    = match_q;
    digit_d    = digit_q;
    fails_d    = fails_q;
    door_d     = door_q;
    light_d    = light_q;
    reply      = ReplyNone;
    user_match = match_q;
    case (phase_q)
      PhUser: begin
        if (byte_i != ChV) begin
          if (byte_i != ChHash) begin
            if (count_q < 3'd4) begin
              if (byte_i != name_char(count_q[1:0])) user_match = 1'b0;
            end else if (count_q == 3'd4) begin
              if (byte_i >= ChZero && byte_i <= ChNine) digit_d = byte_i[3:0];
              else user_match = 1'b0;
            end
            count_d = count_inc;
            match_d = user_match;
          end
          // The name ends on '#' or once six bytes have been counted.
          if (byte_i == ChHash || count_d == 3'd6) begin
            count_d = 3'd0;
            match_d = 1'b1;
            if (user_match && ((byte_i == ChHash) ? count_q : count_inc) >= 3'd5) begin
              fails_d = 4'd0;
              phase_d = PhPass;
              reply   = ReplyUserOk;
            end else begin
              reply   = ReplyUnknown;
            end
          end
        end
      end
      PhPass: begin
        if (byte_i == ChV) begin
          phase_d = PhUser;
          count_d = 3'd0;
          match_d = 1'b1;
        end else if (byte_i != ChHash) begin
          // Long attempts saturate at four counted bytes.
          if (count_q < 3'd4) begin
            if (byte_i != pass_char) match_d = 1'b0;
            count_d = count_inc;
          end
        end else begin
          count_d = 3'd0;
          match_d = 1'b1;
          if (match_q && count_q >= 3'd4) begin
            phase_d = PhCmd;
            reply   = ReplyPassOk;
          end else begin
            fails_d = fails_inc;
            reply   = ReplyPassBad;
            if (fails_inc >= max_att_q) phase_d = PhLock;
          end
        end
      end
      PhCmd: begin
        case (byte_i)
          ChP:     door_d = 1'b1;
          ChC:     door_d = 1'b0;
          ChH:     light_d = 1'b1;
          ChL:     light_d = 1'b0;
          ChN, ChV: begin
            phase_d = PhUser;
            count_d = 3'd0;
            match_d = 1'b1;
          end
          default: reply = ReplyBadAct;
        endcase
      end
      default: reply = ReplyLocked;
    endcase
  end

  assign result_o = '{reply: reply, door: door_d, light: light_d,
                      locked: (phase_d == PhLock)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhUser;
      count_q   <= 3'd0;
      match_q   <= 1'b1;
      digit_q   <= 4'd0;
      fails_q   <= 4'd0;
      door_q    <= 1'b0;
      light_q   <= 1'b0;
      max_att_q <= MaxAttemptsReset;
    end else begin
      if (cfg_we_i) max_att_q <= cfg_wdata_i;
      if (step_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
        match_q <= match_d;
        digit_q <= digit_d;
        fails_q <= fails_d;
        door_q  <= door_d;
        light_q <= light_d;
      end
    end
  end

endmodule
